// ===== hdl/rewt_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths and codes for the rope edge wrap test pipeline.
// Used by every module of the block; depends on nothing.
package rewt_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int DIFF_W      = 32;
    localparam int QUAT_W      = 32;
    localparam int AXIS_W      = 34;
    localparam int TOL_W       = 17;
    localparam int TOLSQ_W     = 32;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_IDX_W   = 3;
    localparam int PROD_SHIFT  = 30;
    localparam int FRAC_W      = 16;
    localparam int SAT_IN_W    = 64;
    localparam int DOT_PROD_W  = DIFF_W + AXIS_W;
    localparam int DOT_W       = DOT_PROD_W - PROD_SHIFT;
    localparam int SUM_W       = DOT_W + 2;
    localparam int LEN_W       = 2 * DIFF_W;
    localparam int QUOT_W      = 20;
    localparam int T_W         = QUOT_W + 1;
    localparam int DEN_W       = DIFF_W;
    localparam int NUM_W       = DIFF_W + FRAC_W;
    localparam int CMP_W       = DEN_W + QUOT_W;

    localparam logic signed [QUAT_W-1:0] Q30_ONE    = QUAT_W'(1) <<< PROD_SHIFT;
    localparam logic [TOL_W-1:0]         TOL_RESET  = TOL_W'(66);
    localparam int                       ONE_Q16    = 1 << FRAC_W;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]      diff_t;
    typedef logic signed [AXIS_W-1:0]      axis_t;
    typedef logic signed [DOT_W-1:0]       dot_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROT_X  = 3'd0,
        REG_ROT_Y  = 3'd1,
        REG_ROT_Z  = 3'd2,
        REG_ROT_W  = 3'd3,
        REG_TOL    = 3'd4,
        REG_TOL_SQ = 3'd5
    } cfg_index_t;

    typedef enum logic [2:0] {
        DEC_NEAR      = 3'd0,
        DEC_SAME_SIDE = 3'd1,
        DEC_PARALLEL  = 3'd2,
        DEC_OUTSIDE   = 3'd3,
        DEC_DOWN      = 3'd4
    } decision_t;

    typedef struct packed {
        logic near;
        logic same;
        logic par;
        logic ovf;
        logic qneg;
    } test_flags_t;

    function automatic diff_t sat_diff(input logic signed [SAT_IN_W-1:0] v);
        if (&v[SAT_IN_W-1:DIFF_W-1] || ~|v[SAT_IN_W-1:DIFF_W-1]) begin
            return diff_t'(v[DIFF_W-1:0]);
        end else if (v[SAT_IN_W-1]) begin
            return {1'b1, {(DIFF_W-1){1'b0}}};
        end else begin
            return {1'b0, {(DIFF_W-1){1'b1}}};
        end
    endfunction

endpackage

// ===== hdl/rewt_cfg.sv =====
`timescale 1ns / 1ps
// Configuration registers and the edge axes derived from the rotation.
// Depends on rewt_pkg.
module rewt_cfg (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [rewt_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [rewt_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    output rewt_pkg::axis_t                 nrm [3],
    output rewt_pkg::axis_t                 down [3],
    output logic [rewt_pkg::TOL_W-1:0]      tol,
    output logic [rewt_pkg::TOLSQ_W-1:0]    tol_sq
);
    import rewt_pkg::*;

    localparam int AX_WIDE = 2 * QUAT_W + 3;
    localparam logic signed [AX_WIDE-1:0] Q60_ONE = AX_WIDE'(1) <<< (2 * PROD_SHIFT);

    function automatic logic signed [QUAT_W-1:0] clamp_q(input logic signed [QUAT_W-1:0] v);
        if (v > Q30_ONE) begin
            return Q30_ONE;
        end else if (v < -Q30_ONE) begin
            return -Q30_ONE;
        end else begin
            return v;
        end
    endfunction

    function automatic axis_t axis_of(input logic signed [AX_WIDE-1:0] v);
        return axis_t'(v >>> PROD_SHIFT);
    endfunction

    logic signed [QUAT_W-1:0] rot_x_reg, rot_y_reg, rot_z_reg, rot_w_reg;
    logic [TOL_W-1:0]         tol_reg;
    logic [TOLSQ_W-1:0]       tol_sq_reg;
    logic signed [QUAT_W-1:0] wr_clamped;

    logic signed [2*QUAT_W-1:0] p_xy_reg, p_wz_reg, p_xx_reg, p_zz_reg, p_yz_reg;
    logic signed [2*QUAT_W-1:0] p_wx_reg, p_xz_reg, p_wy_reg, p_yy_reg;
    axis_t                      nrm_reg [3];
    axis_t                      down_reg [3];
    axis_t                      nrm_next [3];
    axis_t                      down_next [3];

    assign wr_clamped = clamp_q(cfg_wr_data);

    // Rotation components are clamped once, on write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rot_x_reg  <= '0;
            rot_y_reg  <= '0;
            rot_z_reg  <= '0;
            rot_w_reg  <= Q30_ONE;
            tol_reg    <= TOL_RESET;
            tol_sq_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                REG_ROT_X:  rot_x_reg  <= wr_clamped;
                REG_ROT_Y:  rot_y_reg  <= wr_clamped;
                REG_ROT_Z:  rot_z_reg  <= wr_clamped;
                REG_ROT_W:  rot_w_reg  <= wr_clamped;
                REG_TOL:    tol_reg    <= cfg_wr_data[TOL_W-1:0];
                REG_TOL_SQ: tol_sq_reg <= cfg_wr_data[TOLSQ_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        p_xy_reg <= rot_x_reg * rot_y_reg;
        p_wz_reg <= rot_w_reg * rot_z_reg;
        p_xx_reg <= rot_x_reg * rot_x_reg;
        p_zz_reg <= rot_z_reg * rot_z_reg;
        p_yz_reg <= rot_y_reg * rot_z_reg;
        p_wx_reg <= rot_w_reg * rot_x_reg;
        p_xz_reg <= rot_x_reg * rot_z_reg;
        p_wy_reg <= rot_w_reg * rot_y_reg;
        p_yy_reg <= rot_y_reg * rot_y_reg;
    end

    // Normal is the rotated Y axis, down the negated rotated Z axis
    always_comb begin
        nrm_next[0]  = axis_of((AX_WIDE'(p_xy_reg) - AX_WIDE'(p_wz_reg)) <<< 1);
        nrm_next[1]  = axis_of(Q60_ONE - ((AX_WIDE'(p_xx_reg) + AX_WIDE'(p_zz_reg)) <<< 1));
        nrm_next[2]  = axis_of((AX_WIDE'(p_yz_reg) + AX_WIDE'(p_wx_reg)) <<< 1);
        down_next[0] = -axis_of((AX_WIDE'(p_xz_reg) + AX_WIDE'(p_wy_reg)) <<< 1);
        down_next[1] = -axis_of((AX_WIDE'(p_yz_reg) - AX_WIDE'(p_wx_reg)) <<< 1);
        down_next[2] = -axis_of(Q60_ONE - ((AX_WIDE'(p_xx_reg) + AX_WIDE'(p_yy_reg)) <<< 1));
    end

    always_ff @(posedge aclk) begin
        nrm_reg  <= nrm_next;
        down_reg <= down_next;
    end

    assign nrm    = nrm_reg;
    assign down   = down_reg;
    assign tol    = tol_reg;
    assign tol_sq = tol_sq_reg;

endmodule

// ===== hdl/rewt_front.sv =====
`timescale 1ns / 1ps
// Front stages: differences, squared lengths, plane distances, the
// same-side and parallel tests and the divider operands. Depends on rewt_pkg.
module rewt_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  rewt_pkg::coord_t             s_a_x,
    input  rewt_pkg::coord_t             s_a_y,
    input  rewt_pkg::coord_t             s_a_z,
    input  rewt_pkg::coord_t             s_b_x,
    input  rewt_pkg::coord_t             s_b_y,
    input  rewt_pkg::coord_t             s_b_z,
    input  rewt_pkg::coord_t             s_c_x,
    input  rewt_pkg::coord_t             s_c_y,
    input  rewt_pkg::coord_t             s_c_z,
    input  rewt_pkg::axis_t              nrm [3],
    input  logic [rewt_pkg::TOL_W-1:0]   tol,
    input  logic [rewt_pkg::TOLSQ_W-1:0] tol_sq,
    output logic                         out_valid,
    input  logic                         out_ready,
    output rewt_pkg::test_flags_t        out_flags,
    output logic [rewt_pkg::NUM_W-1:0]   out_num,
    output logic [rewt_pkg::DEN_W-1:0]   out_den,
    output rewt_pkg::diff_t              out_ab [3],
    output rewt_pkg::diff_t              out_ac [3]
);
    import rewt_pkg::*;

    localparam int NSTG = 6;

    function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] p0,
                                                 input logic [LEN_W-1:0] p1,
                                                 input logic [LEN_W-1:0] p2);
        logic [LEN_W:0] s01;
        logic [LEN_W:0] s;
        s01 = {1'b0, p0} + {1'b0, p1};
        if (s01[LEN_W]) begin
            return '1;
        end
        s = {1'b0, s01[LEN_W-1:0]} + {1'b0, p2};
        if (s[LEN_W]) begin
            return '1;
        end
        return s[LEN_W-1:0];
    endfunction

    logic [NSTG-1:0] v_reg;
    logic [NSTG-1:0] v_next;
    logic [NSTG:0]   rdy;

    assign rdy[NSTG] = out_ready;
    assign v_next    = {v_reg[NSTG-2:0], s_valid};

    for (genvar g = 0; g < NSTG; g++) begin : g_rdy
        assign rdy[g] = !v_reg[g] || rdy[g+1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            for (int i = 0; i < NSTG; i++) begin
                if (rdy[i]) begin
                    v_reg[i] <= v_next[i];
                end
            end
        end
    end

    // Stage 1: capture the request
    coord_t a_reg [3];
    coord_t b_reg [3];
    coord_t c_reg [3];

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            a_reg <= '{s_a_x, s_a_y, s_a_z};
            b_reg <= '{s_b_x, s_b_y, s_b_z};
            c_reg <= '{s_c_x, s_c_y, s_c_z};
        end
    end

    // Stage 2: saturated differences
    diff_t ba_reg [3];
    diff_t bc_reg [3];
    diff_t ab2_reg [3];
    diff_t cb_reg [3];
    diff_t ac2_reg [3];

    always_ff @(posedge aclk) begin
        if (rdy[1]) begin
            for (int i = 0; i < 3; i++) begin
                ba_reg[i]  <= sat_diff(SAT_IN_W'(b_reg[i]) - SAT_IN_W'(a_reg[i]));
                bc_reg[i]  <= sat_diff(SAT_IN_W'(b_reg[i]) - SAT_IN_W'(c_reg[i]));
                ab2_reg[i] <= sat_diff(SAT_IN_W'(a_reg[i]) - SAT_IN_W'(b_reg[i]));
                cb_reg[i]  <= sat_diff(SAT_IN_W'(c_reg[i]) - SAT_IN_W'(b_reg[i]));
                ac2_reg[i] <= sat_diff(SAT_IN_W'(c_reg[i]) - SAT_IN_W'(a_reg[i]));
            end
        end
    end

    // Stage 3: squares and normal products
    logic [LEN_W-1:0]            sq_ba_reg [3];
    logic [LEN_W-1:0]            sq_bc_reg [3];
    dot_t                        pa_reg [3];
    dot_t                        pc_reg [3];
    dot_t                        pd_reg [3];
    diff_t                       ab3_reg [3];
    diff_t                       ac3_reg [3];
    logic signed [DOT_PROD_W-1:0] pa_prod [3];
    logic signed [DOT_PROD_W-1:0] pc_prod [3];
    logic signed [DOT_PROD_W-1:0] pd_prod [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            pa_prod[i] = DOT_PROD_W'(ab2_reg[i]) * DOT_PROD_W'(nrm[i]);
            pc_prod[i] = DOT_PROD_W'(cb_reg[i]) * DOT_PROD_W'(nrm[i]);
            pd_prod[i] = DOT_PROD_W'(ac2_reg[i]) * DOT_PROD_W'(nrm[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[2]) begin
            for (int i = 0; i < 3; i++) begin
                sq_ba_reg[i] <= LEN_W'(LEN_W'(ba_reg[i]) * LEN_W'(ba_reg[i]));
                sq_bc_reg[i] <= LEN_W'(LEN_W'(bc_reg[i]) * LEN_W'(bc_reg[i]));
                pa_reg[i]    <= dot_t'(pa_prod[i] >>> PROD_SHIFT);
                pc_reg[i]    <= dot_t'(pc_prod[i] >>> PROD_SHIFT);
                pd_reg[i]    <= dot_t'(pd_prod[i] >>> PROD_SHIFT);
            end
            ab3_reg <= ab2_reg;
            ac3_reg <= ac2_reg;
        end
    end

    // Stage 4: anchor proximity and plane distances
    logic                    near4_reg;
    diff_t                   da4_reg, dc4_reg, den4_reg;
    diff_t                   ab4_reg [3];
    diff_t                   ac4_reg [3];
    logic [LEN_W-1:0]        len_ba, len_bc;
    logic signed [SUM_W-1:0] sum_a, sum_c, sum_d;

    always_comb begin
        len_ba = sat_len(sq_ba_reg[0], sq_ba_reg[1], sq_ba_reg[2]);
        len_bc = sat_len(sq_bc_reg[0], sq_bc_reg[1], sq_bc_reg[2]);
        sum_a  = SUM_W'(pa_reg[0]) + SUM_W'(pa_reg[1]) + SUM_W'(pa_reg[2]);
        sum_c  = SUM_W'(pc_reg[0]) + SUM_W'(pc_reg[1]) + SUM_W'(pc_reg[2]);
        sum_d  = SUM_W'(pd_reg[0]) + SUM_W'(pd_reg[1]) + SUM_W'(pd_reg[2]);
    end

    always_ff @(posedge aclk) begin
        if (rdy[3]) begin
            near4_reg <= (len_ba < LEN_W'(tol_sq)) || (len_bc < LEN_W'(tol_sq));
            da4_reg   <= sat_diff(SAT_IN_W'(sum_a));
            dc4_reg   <= sat_diff(SAT_IN_W'(sum_c));
            den4_reg  <= sat_diff(SAT_IN_W'(sum_d));
            ab4_reg   <= ab3_reg;
            ac4_reg   <= ac3_reg;
        end
    end

    // Stage 5: distance product, parallel test, divider magnitudes
    logic signed [LEN_W-1:0]  dd5_reg;
    logic                     near5_reg, par5_reg, qneg5_reg;
    logic [NUM_W-1:0]         num5_reg;
    logic [DEN_W-1:0]         den5_reg;
    diff_t                    ab5_reg [3];
    diff_t                    ac5_reg [3];
    logic signed [DIFF_W:0]   tol_ext, den_ext, da_ext, den_mag, da_mag;
    logic                     par_next;

    always_comb begin
        tol_ext  = {{(DIFF_W-TOL_W+1){1'b0}}, tol};
        den_ext  = {den4_reg[DIFF_W-1], den4_reg};
        da_ext   = {da4_reg[DIFF_W-1], da4_reg};
        den_mag  = den_ext[DIFF_W] ? -den_ext : den_ext;
        da_mag   = da_ext[DIFF_W] ? -da_ext : da_ext;
        par_next = (den4_reg == '0) || ((den_ext < tol_ext) && (den_ext > -tol_ext));
    end

    always_ff @(posedge aclk) begin
        if (rdy[4]) begin
            dd5_reg   <= LEN_W'(da4_reg) * LEN_W'(dc4_reg);
            near5_reg <= near4_reg;
            par5_reg  <= par_next;
            // t = -dA / den is negative when both share a sign
            qneg5_reg <= (da4_reg[DIFF_W-1] == den4_reg[DIFF_W-1]);
            num5_reg  <= {da_mag[DIFF_W-1:0], {FRAC_W{1'b0}}};
            den5_reg  <= den_mag[DEN_W-1:0];
            ab5_reg   <= ab4_reg;
            ac5_reg   <= ac4_reg;
        end
    end

    // Stage 6: same-side test and quotient overflow
    test_flags_t             flags6_reg;
    logic [NUM_W-1:0]        num6_reg;
    logic [DEN_W-1:0]        den6_reg;
    diff_t                   ab6_reg [3];
    diff_t                   ac6_reg [3];
    logic signed [LEN_W-1:0] tol_lim;
    test_flags_t             flags6_next;

    always_comb begin
        tol_lim          = LEN_W'({tol, {FRAC_W{1'b0}}});
        flags6_next.near = near5_reg;
        flags6_next.same = dd5_reg > tol_lim;
        flags6_next.par  = par5_reg;
        flags6_next.ovf  = CMP_W'(num5_reg) >= {den5_reg, {QUOT_W{1'b0}}};
        flags6_next.qneg = qneg5_reg;
    end

    always_ff @(posedge aclk) begin
        if (rdy[5]) begin
            flags6_reg <= flags6_next;
            num6_reg   <= num5_reg;
            den6_reg   <= den5_reg;
            ab6_reg    <= ab5_reg;
            ac6_reg    <= ac5_reg;
        end
    end

    assign s_ready   = rdy[0];
    assign out_valid = v_reg[NSTG-1];
    assign out_flags = flags6_reg;
    assign out_num   = num6_reg;
    assign out_den   = den6_reg;
    assign out_ab    = ab6_reg;
    assign out_ac    = ac6_reg;

endmodule

// ===== hdl/rewt_div.sv =====
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per pipeline stage, for the
// intersection parameter. Depends on rewt_pkg.
module rewt_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  rewt_pkg::test_flags_t       in_flags,
    input  logic [rewt_pkg::NUM_W-1:0]  in_num,
    input  logic [rewt_pkg::DEN_W-1:0]  in_den,
    input  rewt_pkg::diff_t             in_ab [3],
    input  rewt_pkg::diff_t             in_ac [3],
    output logic                        out_valid,
    input  logic                        out_ready,
    output rewt_pkg::test_flags_t       out_flags,
    output logic [rewt_pkg::QUOT_W-1:0] out_quot,
    output rewt_pkg::diff_t             out_ab [3],
    output rewt_pkg::diff_t             out_ac [3]
);
    import rewt_pkg::*;

    localparam int NSTG = QUOT_W;

    logic [NSTG-1:0]   v_reg;
    logic [NSTG-1:0]   v_next;
    logic [NSTG:0]     rdy;

    logic [NUM_W-1:0]  rem_reg  [NSTG];
    logic [DEN_W-1:0]  den_reg  [NSTG];
    logic [QUOT_W-1:0] quot_reg [NSTG];
    test_flags_t       flags_reg [NSTG];
    diff_t             ab_reg [NSTG][3];
    diff_t             ac_reg [NSTG][3];

    assign rdy[NSTG] = out_ready;
    assign v_next    = {v_reg[NSTG-2:0], in_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            for (int i = 0; i < NSTG; i++) begin
                if (rdy[i]) begin
                    v_reg[i] <= v_next[i];
                end
            end
        end
    end

    for (genvar g = 0; g < NSTG; g++) begin : g_stg
        logic [NUM_W-1:0]  rem_in;
        logic [DEN_W-1:0]  den_in;
        logic [QUOT_W-1:0] quot_in;
        test_flags_t       flags_in;
        diff_t             ab_in [3];
        diff_t             ac_in [3];
        logic [CMP_W-1:0]  trial;
        logic [CMP_W:0]    diff;

        if (g == 0) begin : g_first
            assign rem_in   = in_num;
            assign den_in   = in_den;
            assign quot_in  = '0;
            assign flags_in = in_flags;
            assign ab_in    = in_ab;
            assign ac_in    = in_ac;
        end else begin : g_later
            assign rem_in   = rem_reg[g-1];
            assign den_in   = den_reg[g-1];
            assign quot_in  = quot_reg[g-1];
            assign flags_in = flags_reg[g-1];
            assign ab_in    = ab_reg[g-1];
            assign ac_in    = ac_reg[g-1];
        end

        assign rdy[g] = !v_reg[g] || rdy[g+1];
        assign trial  = CMP_W'(den_in) << (QUOT_W - 1 - g);
        assign diff   = {1'b0, CMP_W'(rem_in)} - {1'b0, trial};

        // Subtract the shifted divisor when it fits, else keep the remainder
        always_ff @(posedge aclk) begin
            if (rdy[g]) begin
                rem_reg[g]   <= diff[CMP_W] ? rem_in : diff[NUM_W-1:0];
                quot_reg[g]  <= quot_in | (diff[CMP_W] ? QUOT_W'(0)
                                                       : QUOT_W'(1) << (QUOT_W - 1 - g));
                den_reg[g]   <= den_in;
                flags_reg[g] <= flags_in;
                ab_reg[g]    <= ab_in;
                ac_reg[g]    <= ac_in;
            end
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = v_reg[NSTG-1];
    assign out_flags = flags_reg[NSTG-1];
    assign out_quot  = quot_reg[NSTG-1];
    assign out_ab    = ab_reg[NSTG-1];
    assign out_ac    = ac_reg[NSTG-1];

`ifndef SYNTHESIS
    a_rem_below_den: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && !out_flags.ovf && (den_reg[NSTG-1] != '0)
        |-> (CMP_W'(rem_reg[NSTG-1]) < CMP_W'(den_reg[NSTG-1])))
        else $error("divider remainder not below divisor");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (v_reg == '0))
        else $error("divider stages hold requests after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && !out_ready |=> out_valid && $stable(out_quot))
        else $error("stalled quotient lost or changed");

    a_first_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        v_reg[0] && !rdy[1] |=> v_reg[0] && $stable(rem_reg[0]))
        else $error("first divider stage dropped a stalled request");
`endif

endmodule

// ===== hdl/rewt_back.sv =====
`timescale 1ns / 1ps
// Back stages: signed intersection parameter, segment test, intersection
// point, down test and the result register. Depends on rewt_pkg.
module rewt_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  rewt_pkg::test_flags_t       in_flags,
    input  logic [rewt_pkg::QUOT_W-1:0] in_quot,
    input  rewt_pkg::diff_t             in_ab [3],
    input  rewt_pkg::diff_t             in_ac [3],
    input  rewt_pkg::axis_t             down [3],
    input  logic [rewt_pkg::TOL_W-1:0]  tol,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_is_wrapping,
    output logic [2:0]                  m_decided_by
);
    import rewt_pkg::*;

    localparam int NSTG  = 5;
    localparam int TC_W  = T_W + 1;
    localparam int MUL_W = T_W + DIFF_W;

    logic [NSTG-1:0] v_reg;
    logic [NSTG-1:0] v_next;
    logic [NSTG:0]   rdy;

    assign rdy[NSTG] = m_ready;
    assign v_next    = {v_reg[NSTG-2:0], in_valid};

    for (genvar g = 0; g < NSTG; g++) begin : g_rdy
        assign rdy[g] = !v_reg[g] || rdy[g+1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            for (int i = 0; i < NSTG; i++) begin
                if (rdy[i]) begin
                    v_reg[i] <= v_next[i];
                end
            end
        end
    end

    // Stage 1: apply the sign and check the segment range
    logic signed [T_W-1:0]  t1_reg;
    logic                   out1_reg;
    test_flags_t            flags1_reg;
    diff_t                  ab1_reg [3];
    diff_t                  ac1_reg [3];
    logic signed [T_W-1:0]  t_mag, t_next;
    logic signed [TC_W-1:0] t_ext, tol_e, lo_lim, hi_lim;

    always_comb begin
        t_mag  = {1'b0, in_quot};
        t_next = in_flags.qneg ? -t_mag : t_mag;
        t_ext  = TC_W'(t_next);
        tol_e  = {{(TC_W-TOL_W){1'b0}}, tol};
        lo_lim = -tol_e;
        hi_lim = TC_W'(ONE_Q16) + tol_e;
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            t1_reg     <= t_next;
            out1_reg   <= in_flags.ovf || (t_ext < lo_lim) || (t_ext > hi_lim);
            flags1_reg <= in_flags;
            ab1_reg    <= in_ab;
            ac1_reg    <= in_ac;
        end
    end

    // Stage 2: t * (C - A)
    logic signed [MUL_W-1:0] m2_reg [3];
    logic                    out2_reg;
    test_flags_t             flags2_reg;
    diff_t                   ab2_reg [3];

    always_ff @(posedge aclk) begin
        if (rdy[1]) begin
            for (int i = 0; i < 3; i++) begin
                m2_reg[i] <= MUL_W'(t1_reg) * MUL_W'(ac1_reg[i]);
            end
            out2_reg   <= out1_reg;
            flags2_reg <= flags1_reg;
            ab2_reg    <= ab1_reg;
        end
    end

    // Stage 3: intersection point relative to B
    diff_t       pb3_reg [3];
    logic        out3_reg;
    test_flags_t flags3_reg;

    always_ff @(posedge aclk) begin
        if (rdy[2]) begin
            for (int i = 0; i < 3; i++) begin
                pb3_reg[i] <= sat_diff(SAT_IN_W'(ab2_reg[i])
                                       + SAT_IN_W'(m2_reg[i] >>> FRAC_W));
            end
            out3_reg   <= out2_reg;
            flags3_reg <= flags2_reg;
        end
    end

    // Stage 4: products with the down axis
    dot_t                         dd4_reg [3];
    logic                         out4_reg;
    test_flags_t                  flags4_reg;
    logic signed [DOT_PROD_W-1:0] dd_prod [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            dd_prod[i] = DOT_PROD_W'(pb3_reg[i]) * DOT_PROD_W'(down[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[3]) begin
            for (int i = 0; i < 3; i++) begin
                dd4_reg[i] <= dot_t'(dd_prod[i] >>> PROD_SHIFT);
            end
            out4_reg   <= out3_reg;
            flags4_reg <= flags3_reg;
        end
    end

    // Stage 5: first deciding test wins
    logic                    wrap_reg, wrap_next;
    decision_t               dec_reg, dec_next;
    logic signed [SUM_W-1:0] along, tol_s;

    always_comb begin
        along = SUM_W'(dd4_reg[0]) + SUM_W'(dd4_reg[1]) + SUM_W'(dd4_reg[2]);
        tol_s = {{(SUM_W-TOL_W){1'b0}}, tol};
        priority if (flags4_reg.near) begin
            wrap_next = 1'b1;
            dec_next  = DEC_NEAR;
        end else if (flags4_reg.same) begin
            wrap_next = 1'b0;
            dec_next  = DEC_SAME_SIDE;
        end else if (flags4_reg.par) begin
            wrap_next = 1'b1;
            dec_next  = DEC_PARALLEL;
        end else if (out4_reg) begin
            wrap_next = 1'b0;
            dec_next  = DEC_OUTSIDE;
        end else begin
            wrap_next = along > -tol_s;
            dec_next  = DEC_DOWN;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[4]) begin
            wrap_reg <= wrap_next;
            dec_reg  <= dec_next;
        end
    end

    assign in_ready      = rdy[0];
    assign m_valid       = v_reg[NSTG-1];
    assign m_is_wrapping = wrap_reg;
    assign m_decided_by  = dec_reg;

endmodule

// ===== hdl/rope_edge_wrap_test_unit.sv =====
`timescale 1ns / 1ps
// Top level of the rope edge wrap test: configuration, front stages,
// divider and back stages. Depends on rewt_pkg and the rewt_* modules.

// Takes one point triple (A, B, C) per clock while s_ready is high and
// returns one result per request, in order: the request passes 31 register
// stages, the first loaded at the accepting edge: 6 front stages
// (differences, products, sums, tests), 20 divider stages and 5 back stages,
// the restoring divider resolving one quotient bit per stage. Every stage
// holds its own valid bit, so a stall at the output only backs up as far as
// the first empty stage. Stages read the tolerances and the derived axes as
// they are, so a rotation or tolerance write can reach requests in flight.
module rope_edge_wrap_test_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [rewt_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [rewt_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  rewt_pkg::coord_t                s_a_x,
    input  rewt_pkg::coord_t                s_a_y,
    input  rewt_pkg::coord_t                s_a_z,
    input  rewt_pkg::coord_t                s_b_x,
    input  rewt_pkg::coord_t                s_b_y,
    input  rewt_pkg::coord_t                s_b_z,
    input  rewt_pkg::coord_t                s_c_x,
    input  rewt_pkg::coord_t                s_c_y,
    input  rewt_pkg::coord_t                s_c_z,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_is_wrapping,
    output logic [2:0]                      m_decided_by
);
    import rewt_pkg::*;

    axis_t             nrm [3];
    axis_t             down [3];
    logic [TOL_W-1:0]  tol;
    logic [TOLSQ_W-1:0] tol_sq;

    logic              fd_valid, fd_ready;
    test_flags_t       fd_flags;
    logic [NUM_W-1:0]  fd_num;
    logic [DEN_W-1:0]  fd_den;
    diff_t             fd_ab [3];
    diff_t             fd_ac [3];

    logic              db_valid, db_ready;
    test_flags_t       db_flags;
    logic [QUOT_W-1:0] db_quot;
    diff_t             db_ab [3];
    diff_t             db_ac [3];

    rewt_cfg u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .nrm          (nrm),
        .down         (down),
        .tol          (tol),
        .tol_sq       (tol_sq)
    );

    rewt_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_a_x     (s_a_x),
        .s_a_y     (s_a_y),
        .s_a_z     (s_a_z),
        .s_b_x     (s_b_x),
        .s_b_y     (s_b_y),
        .s_b_z     (s_b_z),
        .s_c_x     (s_c_x),
        .s_c_y     (s_c_y),
        .s_c_z     (s_c_z),
        .nrm       (nrm),
        .tol       (tol),
        .tol_sq    (tol_sq),
        .out_valid (fd_valid),
        .out_ready (fd_ready),
        .out_flags (fd_flags),
        .out_num   (fd_num),
        .out_den   (fd_den),
        .out_ab    (fd_ab),
        .out_ac    (fd_ac)
    );

    rewt_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fd_valid),
        .in_ready  (fd_ready),
        .in_flags  (fd_flags),
        .in_num    (fd_num),
        .in_den    (fd_den),
        .in_ab     (fd_ab),
        .in_ac     (fd_ac),
        .out_valid (db_valid),
        .out_ready (db_ready),
        .out_flags (db_flags),
        .out_quot  (db_quot),
        .out_ab    (db_ab),
        .out_ac    (db_ac)
    );

    rewt_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (db_valid),
        .in_ready      (db_ready),
        .in_flags      (db_flags),
        .in_quot       (db_quot),
        .in_ab         (db_ab),
        .in_ac         (db_ac),
        .down          (down),
        .tol           (tol),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_is_wrapping (m_is_wrapping),
        .m_decided_by  (m_decided_by)
    );

endmodule

// ===== verif/tb_rope_edge_wrap_test_unit.sv =====
`timescale 1ns / 1ps
// Self-checking bench for rope_edge_wrap_test_unit: directed and random point
// triples under several edge rotations, checked against a local wrap predictor.
module tb_rope_edge_wrap_test_unit;
    import rewt_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 60;

    typedef struct {
        logic      wrap;
        decision_t reason;
    } wrap_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_wr_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    coord_t s_a_x = '0, s_a_y = '0, s_a_z = '0;
    coord_t s_b_x = '0, s_b_y = '0, s_b_z = '0;
    coord_t s_c_x = '0, s_c_y = '0, s_c_z = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_is_wrapping;
    logic [2:0] m_decided_by;

    // shadow of the configuration registers
    longint rot_q[4];
    longint tol_v;
    longint tolsq_v;

    wrap_result_t pending_results[$];
    int  fail_count = 0;
    int  result_count = 0;
    int  sent_count = 0;
    int  stall_pct_s = 0;
    int  stall_pct_m = 0;
    bit  hold_off = 1'b0;
    int  idle_cycles = 0;
    bit  done = 1'b0;

    rope_edge_wrap_test_unit DUT (.*);

    always #5 aclk = ~aclk;

    function automatic longint fshr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint clamp_q30(longint v);
        if (v > 64'sd1073741824) return 64'sd1073741824;
        if (v < -64'sd1073741824) return -64'sd1073741824;
        return v;
    endfunction

    function automatic longint dot_axis(longint d[3], longint ax[3]);
        longint s = 0;
        for (int i = 0; i < 3; i++) s += fshr(d[i] * ax[i], 30);
        return s;
    endfunction

    function automatic logic [63:0] len_sq(longint d[3]);
        logic [63:0] s = 0;
        logic [63:0] t;
        for (int i = 0; i < 3; i++) begin
            t = d[i] * d[i];
            if (s > 64'hFFFF_FFFF_FFFF_FFFF - t) return 64'hFFFF_FFFF_FFFF_FFFF;
            s += t;
        end
        return s;
    endfunction

    function automatic wrap_result_t predict_wrap(coord_t p[9]);
        longint a[3], b[3], c[3], nrm[3], dn[3];
        longint ba[3], bc[3], ab[3], cb[3], ac[3], pb[3];
        longint x, y, z, w, da, dc, den, t, along;
        longint one60;
        wrap_result_t r;
        one60 = 64'sd1 <<< 60;
        x = clamp_q30(rot_q[0]); y = clamp_q30(rot_q[1]);
        z = clamp_q30(rot_q[2]); w = clamp_q30(rot_q[3]);
        for (int i = 0; i < 3; i++) begin
            a[i] = p[i]; b[i] = p[3+i]; c[i] = p[6+i];
        end
        nrm[0] = fshr(2 * (x * y - w * z), 30);
        nrm[1] = fshr(one60 - 2 * (x * x + z * z), 30);
        nrm[2] = fshr(2 * (y * z + w * x), 30);
        dn[0] = -fshr(2 * (x * z + w * y), 30);
        dn[1] = -fshr(2 * (y * z - w * x), 30);
        dn[2] = -fshr(one60 - 2 * (x * x + y * y), 30);
        for (int i = 0; i < 3; i++) begin
            ba[i] = sat32(b[i] - a[i]); bc[i] = sat32(b[i] - c[i]);
            ab[i] = sat32(a[i] - b[i]); cb[i] = sat32(c[i] - b[i]);
            ac[i] = sat32(c[i] - a[i]);
        end
        if (len_sq(ba) < tolsq_v || len_sq(bc) < tolsq_v) begin
            r.wrap = 1'b1; r.reason = DEC_NEAR; return r;
        end
        da = sat32(dot_axis(ab, nrm));
        dc = sat32(dot_axis(cb, nrm));
        if (da * dc > tol_v * 65536) begin
            r.wrap = 1'b0; r.reason = DEC_SAME_SIDE; return r;
        end
        den = sat32(dot_axis(ac, nrm));
        if (den == 0 || (den < tol_v && den > -tol_v)) begin
            r.wrap = 1'b1; r.reason = DEC_PARALLEL; return r;
        end
        t = (-da * 65536) / den;
        if (t < -tol_v || t > 65536 + tol_v) begin
            r.wrap = 1'b0; r.reason = DEC_OUTSIDE; return r;
        end
        for (int i = 0; i < 3; i++) pb[i] = sat32(ab[i] + fshr(t * ac[i], 16));
        along = dot_axis(pb, dn);
        r.wrap = (along > -tol_v);
        r.reason = DEC_DOWN;
        return r;
    endfunction

    task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_ROT_X:  rot_q[0] = longint'($signed(data));
            REG_ROT_Y:  rot_q[1] = longint'($signed(data));
            REG_ROT_Z:  rot_q[2] = longint'($signed(data));
            REG_ROT_W:  rot_q[3] = longint'($signed(data));
            REG_TOL:    tol_v = data & 32'h1FFFF;
            REG_TOL_SQ: tolsq_v = data;
            default: ;
        endcase
    endtask

    task automatic set_edge(int qx, int qy, int qz, int qw, int tol, int unsigned tsq);
        write_reg(REG_ROT_X, qx);
        write_reg(REG_ROT_Y, qy);
        write_reg(REG_ROT_Z, qz);
        write_reg(REG_ROT_W, qw);
        write_reg(REG_TOL, tol);
        write_reg(REG_TOL_SQ, tsq);
    endtask

    // drop valid, wait for every pending result, then let the pipe settle
    task automatic drain();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // valid stays high after acceptance until the next idle cycle or drain
    task automatic send_points(coord_t p[9]);
        while ($urandom_range(99) < stall_pct_s) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        {s_a_x, s_a_y, s_a_z} <= {p[0], p[1], p[2]};
        {s_b_x, s_b_y, s_b_z} <= {p[3], p[4], p[5]};
        {s_c_x, s_c_y, s_c_z} <= {p[6], p[7], p[8]};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_results.push_back(predict_wrap(p));
        sent_count++;
    endtask

    function automatic coord_t rand_coord(int mode);
        case (mode)
            0: return $urandom;
            1: return $signed($urandom_range(0, 20 << 16)) - (10 << 16);
            default: return $signed($urandom_range(0, 600)) - 300;
        endcase
    endfunction

    // build a random triple; in mode 1, half the time, one that straddles y = 0 near B, so the down test can be reached
    task automatic send_random(int mode);
        coord_t p[9];
        int m;
        for (int i = 0; i < 9; i++) begin
            m = (mode == 3) ? $urandom_range(0, 2) : mode;
            p[i] = rand_coord(m);
        end
        if (mode == 1 && $urandom_range(1)) begin
            p[1] = $signed($urandom_range(1, 8 << 16));
            p[7] = -$signed($urandom_range(1, 8 << 16));
            p[4] = $signed($urandom_range(0, 2 << 16)) - (1 << 16);
        end
        send_points(p);
    endtask

    task automatic test_directed();
        coord_t p[9];
        coord_t ext[4] = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0, -32'sd1};
        // B coincides with A; with the squared tolerance at zero this is no near case
        p = '{0, 0, 0, 0, 0, 0, 65536, 65536, 0};
        send_points(p);
        // both neighbours above the plane: same side
        p = '{0, 65536, 0, 0, 0, 0, 65536, 131072, 0};
        send_points(p);
        // A and C level but both below B: same side, ahead of the parallel test
        p = '{0, 0, 0, 65536, 65536, 0, 131072, 0, 0};
        send_points(p);
        // A and C both above B: same side
        p = '{0, 65536, 0, 0, 0, 0, 65536, 65535, 0};
        send_points(p);
        // crossing mid segment, B above or below: down test both ways
        p = '{-65536, 65536, 0, 0, 0, 65536, 65536, -65536, 0};
        send_points(p);
        p = '{-65536, 65536, 0, 0, 0, -65536, 65536, -65536, 0};
        send_points(p);
        // coordinate extremes, saturating differences
        foreach (ext[i]) begin
            foreach (p[j]) p[j] = ext[(i + j) % 4];
            send_points(p);
        end
        for (int i = 0; i < 9; i++) begin
            foreach (p[j]) p[j] = (j == i) ? ext[0] : ext[1];
            send_points(p);
        end
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++) send_random($urandom_range(0, 3));
    endtask

    task automatic test_backpressure();
        hold_off = 1'b1;
        for (int i = 0; i < 80; i++) send_random(1);
        drain();
    endtask

    task automatic test_rotations();
        int unsigned qneg;
        qneg = 32'hC000_0000;
        drain();
        // 90 degrees about X, and the clamped extremes
        set_edge(32'd759250125, 0, 0, 32'd759250125, 0, 32'hFFFF_FFFF);
        test_random(40);
        drain();
        set_edge(32'h7FFF_FFFF, 32'h8000_0000, qneg, 32'h4000_0000, 32'h1FFFF, 0);
        test_random(40);
        drain();
        set_edge($urandom, $urandom, $urandom, $urandom, $urandom_range(0, 65536), $urandom);
        test_random(60);
        drain();
        set_edge(0, 0, 0, 32'h4000_0000, 66, 32'd100000);
        test_random(60);
    endtask

    // result checker and receiver stall
    always @(posedge aclk) begin
        wrap_result_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            result_count <= result_count + 1;
            if (pending_results.size() == 0) begin
                $error("result with nothing pending: wrap %0b reason %0d",
                       m_is_wrapping, m_decided_by);
                fail_count++;
            end else begin
                exp_r = pending_results.pop_front();
                if (m_is_wrapping !== exp_r.wrap) begin
                    $error("is_wrapping expected %0b actual %0b", exp_r.wrap, m_is_wrapping);
                    fail_count++;
                end
                if (m_decided_by !== exp_r.reason) begin
                    $error("decided_by expected %0d actual %0d", exp_r.reason, m_decided_by);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (hold_off) begin
            m_ready <= 1'b0;
            if (idle_cycles == 300) begin
                hold_off <= 1'b0;
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct_m);
        end
    end

    // watchdog on cycles without any accepted request or result
    int quiet = 0;
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn || done) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet >= WATCHDOG_LIMIT) begin
            $display("tb_rope_edge_wrap_test_unit failed");
            $finish;
        end
    end

    initial begin
        rot_q = '{0, 0, 0, 64'sd1073741824};
        tol_v = 66;
        tolsq_v = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        stall_pct_s = 9; stall_pct_m = 65;
        test_directed();
        test_random(300);
        test_backpressure();
        stall_pct_s = 65; stall_pct_m = 9;
        test_rotations();
        drain();
        stall_pct_s = 0; stall_pct_m = 0;
        set_edge(32'd759250125, 32'd379625062, 0, 32'd657506090, 32'h10000, 32'd4096);
        test_random(350);
        drain();
        done = 1'b1;
        $display("Covered %0d requests, %0d results over directed cases, six register",
                 sent_count, result_count);
        $display("settings, random triples and a long output hold-off.");
        if (fail_count == 0) begin
            $display("tb_rope_edge_wrap_test_unit passed");
        end else begin
            $display("tb_rope_edge_wrap_test_unit failed");
        end
        $finish;
    end
endmodule

// ===== files.f =====
hdl/rewt_pkg.sv
hdl/rewt_cfg.sv
hdl/rewt_front.sv
hdl/rewt_div.sv
hdl/rewt_back.sv
hdl/rope_edge_wrap_test_unit.sv
verif/tb_rope_edge_wrap_test_unit.sv
